// ===== hw/rtl/bsrmv_pkg.sv =====
// shared types and constants for the block sparse row matrix-vector core
`default_nettype none

package bsrmv_pkg;

    localparam int LANES   = 6;
    localparam int VAL_W   = 32;
    localparam int COL_W   = 12;
    localparam int LROW_W  = 3;
    localparam int TYPE_W  = 2;
    localparam int ROW_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 3;
    localparam int WIDE_W  = PROD_W + 4;
    localparam int GROUP_W = LANES * VAL_W;

    localparam int IN_FIELDS_W  = COL_W + LROW_W + GROUP_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ROW_W + LANES * PROD_W;

    localparam logic signed [PROD_W-1:0] ACC_MAX = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] ACC_MIN = {1'b1, {(PROD_W-1){1'b0}}};

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SLICE = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef t_prod [LANES-1:0] t_prod_arr;

    // sideband that travels with a slice or close through the pipeline
    typedef struct packed {
        logic              close;
        logic              last;
        logic [LROW_W-1:0] lrow;
    } t_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/bsrmv_ram.sv =====
// generic single-port-write, registered-read RAM
`default_nettype none

module bsrmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/bsrmv_lane.sv =====
// one multiplier lane: matrix entry times vector element, registered
`default_nettype none

module bsrmv_lane (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [bsrmv_pkg::VAL_W-1:0]  i_a,
    input  wire logic signed [bsrmv_pkg::VAL_W-1:0]  i_x,
    output bsrmv_pkg::t_prod                         o_prod
);

    import bsrmv_pkg::*;

    t_prod prod;
    t_prod r_prod;

    // q8.24 times q8.24 is an exact q16.48
    assign prod = t_prod'(i_a) * t_prod'(i_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hw/rtl/bsrmv_merge.sv =====
// two-stage adder tree that merges the six lane products
`default_nettype none

module bsrmv_merge (
    input  wire logic                                i_clk,
    input  wire logic                                i_pair_en,
    input  wire logic                                i_sum_en,
    input  wire bsrmv_pkg::t_prod_arr                i_prod,
    output logic signed [bsrmv_pkg::SUM_W-1:0]       o_sum
);

    import bsrmv_pkg::*;

    localparam int PAIRS = LANES / 2;

    logic signed [PAIR_W-1:0] r_pair [PAIRS];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  sum;

    always_ff @(posedge i_clk) begin
        if (i_pair_en) begin
            for (int k = 0; k < PAIRS; k++) begin
                r_pair[k] <= PAIR_W'($signed(i_prod[2*k])) + PAIR_W'($signed(i_prod[2*k+1]));
            end
        end
        if (i_sum_en) begin
            r_sum <= sum;
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < PAIRS; k++) begin
            sum = sum + SUM_W'(r_pair[k]);
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/block6_sparse_row_matvec_core.sv =====
// top level of the block sparse row matrix-vector core with 6x6 blocks
`default_nettype none

// Takes one word per clock cycle on the slave stream unless the pipeline stalls, and gives
// one block row result per cycle at most on the master stream. A load word writes six Q8.24
// vector values of one block column into the vector RAM in the cycle it is taken; a slice
// word reads that RAM, goes through six 32x32 multiplier lanes, a two-level adder tree and
// the Q16.48 saturating accumulator of its local row. The word that closes the block row
// reaches the output through the RAM read register, the lane register, the two tree
// registers and the output register; slices of the same row may follow each other in
// consecutive cycles. Reading a vector group that was never loaded gives undefined sums.
// The pipeline stalls only when a result waits at the output and the next one is due.
module block6_sparse_row_matvec_core #(
    parameter int VECTOR_GROUPS = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // block_col, local_row, val0..val5, zero pad
    input  wire logic [bsrmv_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // req_type
    input  wire logic [bsrmv_pkg::TYPE_W-1:0]         i_s_axis_tuser,
    input  wire logic                                 i_s_axis_tlast,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // block_row, y0..y5
    output logic [bsrmv_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    // saturated
    output logic [0:0]                                o_m_axis_tuser
);

    import bsrmv_pkg::*;

    localparam int AW = (VECTOR_GROUPS > 1) ? $clog2(VECTOR_GROUPS) : 1;
    localparam int VAL_LSB = COL_W + LROW_W;

    // input fields
    t_req               in_type;
    logic [COL_W-1:0]   in_col;
    logic [LROW_W-1:0]  in_lrow;
    logic [GROUP_W-1:0] in_vals;
    logic               in_col_ok;
    logic               s_accept;
    logic               a_load;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [GROUP_W-1:0] ram_rdata;

    // pipeline registers
    logic                     r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    t_ctl                     r_a_ctl, r_b_ctl, r_c_ctl, r_d_ctl;
    logic                     r_a_col_ok;
    logic [GROUP_W-1:0]       r_a_mat;
    logic                     a_go, b_go, c_go, d_go;
    logic                     b_ready, c_ready, d_ready;
    t_prod_arr                lane_prod;
    logic signed [SUM_W-1:0]  d_sum;

    // accumulator stage
    logic signed [PROD_W-1:0] r_acc [LANES];
    logic signed [PROD_W-1:0] n_acc [LANES];
    logic                     r_clip, n_clip;
    logic [ROW_W-1:0]         r_row_cnt;
    logic signed [PROD_W-1:0] sel_acc;
    logic signed [WIDE_W-1:0] wide;
    logic signed [PROD_W-1:0] sat_val;
    logic                     ovf;
    logic                     upd;
    logic                     d_emit;

    // output register
    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_out_row;
    logic signed [PROD_W-1:0] r_out_y [LANES];
    logic                     r_out_sat;

    assign in_type   = t_req'(i_s_axis_tuser);
    assign in_col    = i_s_axis_tdata[COL_W-1:0];
    assign in_lrow   = i_s_axis_tdata[COL_W +: LROW_W];
    assign in_vals   = i_s_axis_tdata[VAL_LSB +: GROUP_W];
    assign in_col_ok = 32'(in_col) < VECTOR_GROUPS;
    assign ram_addr  = AW'(in_col);

    // stall chain, only an emitting item is held by the output register
    assign d_go    = r_d_valid && (!d_emit || !r_out_valid || i_m_axis_tready);
    assign d_ready = !r_d_valid || d_go;
    assign c_go    = r_c_valid && d_ready;
    assign c_ready = !r_c_valid || c_go;
    assign b_go    = r_b_valid && c_ready;
    assign b_ready = !r_b_valid || b_go;
    assign a_go    = r_a_valid && b_ready;

    assign o_s_axis_tready = !r_a_valid || a_go;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign ram_we          = s_accept && (in_type == REQ_LOAD) && in_col_ok;
    assign a_load          = s_accept && (in_type == REQ_SLICE || in_type == REQ_CLOSE);

    bsrmv_ram #(
        .WIDTH (GROUP_W),
        .DEPTH (VECTOR_GROUPS),
        .AW    (AW)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (in_vals),
        .i_re    (a_load),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (a_load) begin
                r_a_valid <= 1'b1;
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end
            if (a_go) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (b_go) begin
                r_c_valid <= 1'b1;
            end else if (c_go) begin
                r_c_valid <= 1'b0;
            end
            if (c_go) begin
                r_d_valid <= 1'b1;
            end else if (d_go) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_ctl.close <= (in_type == REQ_CLOSE);
            r_a_ctl.last  <= i_s_axis_tlast;
            r_a_ctl.lrow  <= in_lrow;
            r_a_col_ok    <= in_col_ok;
            r_a_mat       <= in_vals;
        end
        if (a_go) begin
            r_b_ctl <= r_a_ctl;
        end
        if (b_go) begin
            r_c_ctl <= r_b_ctl;
        end
        if (c_go) begin
            r_d_ctl <= r_c_ctl;
        end
    end

    // out-of-range groups read as a zero vector
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic signed [VAL_W-1:0] lane_x;

        assign lane_x = r_a_col_ok ? $signed(ram_rdata[k*VAL_W +: VAL_W]) : '0;

        bsrmv_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (a_go),
            .i_a    ($signed(r_a_mat[k*VAL_W +: VAL_W])),
            .i_x    (lane_x),
            .o_prod (lane_prod[k])
        );
    end

    bsrmv_merge u_merge (
        .i_clk     (i_clk),
        .i_pair_en (b_go),
        .i_sum_en  (c_go),
        .i_prod    (lane_prod),
        .o_sum     (d_sum)
    );

    always_comb begin
        sel_acc = '0;
        for (int k = 0; k < LANES; k++) begin
            if (r_d_ctl.lrow == LROW_W'(k)) begin
                sel_acc = r_acc[k];
            end
        end
        upd  = !r_d_ctl.close && (r_d_ctl.lrow < LROW_W'(LANES));
        wide = WIDE_W'(sel_acc) + WIDE_W'(d_sum);
        // exact total fits 64 bits only if the top bits are all sign copies
        ovf  = !((&wide[WIDE_W-1:PROD_W-1]) || !(|wide[WIDE_W-1:PROD_W-1]));
        if (ovf) begin
            sat_val = wide[WIDE_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_val = wide[PROD_W-1:0];
        end
        n_acc  = r_acc;
        n_clip = r_clip;
        if (upd) begin
            for (int k = 0; k < LANES; k++) begin
                if (r_d_ctl.lrow == LROW_W'(k)) begin
                    n_acc[k] = sat_val;
                end
            end
            n_clip = r_clip || ovf;
        end
        d_emit = r_d_ctl.close || r_d_ctl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_acc[k] <= '0;
            end
            r_clip    <= 1'b0;
            r_row_cnt <= '0;
        end else if (d_go) begin
            if (d_emit) begin
                for (int k = 0; k < LANES; k++) begin
                    r_acc[k] <= '0;
                end
                r_clip    <= 1'b0;
                r_row_cnt <= r_row_cnt + 1'b1;
            end else begin
                r_acc  <= n_acc;
                r_clip <= n_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (d_go && d_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_go && d_emit) begin
            r_out_row <= r_row_cnt;
            r_out_y   <= n_acc;
            r_out_sat <= n_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_sat;

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[ROW_W-1:0] = r_out_row;
        for (int k = 0; k < LANES; k++) begin
            o_m_axis_tdata[ROW_W + k*PROD_W +: PROD_W] = r_out_y[k];
        end
    end

    // a closed block row leaves cleared sums and clip flag behind
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_go && d_emit) |=> (r_acc[0] == '0 && r_acc[1] == '0 && r_acc[2] == '0 &&
                              r_acc[3] == '0 && r_acc[4] == '0 && r_acc[5] == '0 && !r_clip))
        else $error("accumulators not cleared after block row close");

    a_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_go && d_emit) |=> (r_row_cnt == ROW_W'($past(r_row_cnt) + 1'b1)))
        else $error("block row counter did not advance on close");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && !d_go) |=> (r_d_valid && $stable(r_d_ctl)))
        else $error("stalled accumulate-stage item lost");

endmodule

`default_nettype wire
